### src/ncdf_pkg.sv
// ncdf_pkg: shared types, Q2.30 coefficient tables and saturation helper
// for the normal cdf polynomial pipeline; no dependencies
`timescale 1ns / 1ps

package ncdf_pkg;

  localparam int HORNER_STEPS = 14;
  localparam int COEF_COUNT = HORNER_STEPS + 1;

  localparam logic signed [31:0] Q30_ONE = 32'sh4000_0000;
  localparam logic [30:0] Z_LIMIT_RESET = 31'd100663296;
  // 2.0 in Q8.24, the small/large region boundary
  localparam logic [31:0] TWO_Q824 = 32'h0200_0000;

  // decimal 1e-12 units to Q2.30, rounded to nearest: n * 2^18 / 5^12
  localparam longint QNum = 64'sd262144;
  localparam longint QHalf = 64'sd122070312;
  localparam longint QDen = 64'sd244140625;

  // large-region coefficients, highest power first
  localparam logic signed [31:0] LARGE_COEF [COEF_COUNT] = '{
    32'(-((64'sd45255659 * QNum + QHalf) / QDen)),
    32'(((64'sd152529290 * QNum + QHalf) / QDen)),
    32'(-((64'sd19538132 * QNum + QHalf) / QDen)),
    32'(-((64'sd676904986 * QNum + QHalf) / QDen)),
    32'(((64'sd1390604284 * QNum + QHalf) / QDen)),
    32'(-((64'sd794620820 * QNum + QHalf) / QDen)),
    32'(-((64'sd2034254874 * QNum + QHalf) / QDen)),
    32'(((64'sd6549791214 * QNum + QHalf) / QDen)),
    32'(-((64'sd10557625006 * QNum + QHalf) / QDen)),
    32'(((64'sd11630447319 * QNum + QHalf) / QDen)),
    32'(-((64'sd9279453341 * QNum + QHalf) / QDen)),
    32'(((64'sd5353579108 * QNum + QHalf) / QDen)),
    32'(-((64'sd2141268741 * QNum + QHalf) / QDen)),
    32'(((64'sd535310849 * QNum + QHalf) / QDen)),
    32'(((64'sd999936657524 * QNum + QHalf) / QDen))
  };

  // small-region coefficients, padded with leading zeros so both regions
  // share the same fourteen horner steps
  localparam logic signed [31:0] SMALL_COEF [COEF_COUNT] = '{
    32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0,
    32'(((64'sd124818987 * QNum + QHalf) / QDen)),
    32'(-((64'sd1075204047 * QNum + QHalf) / QDen)),
    32'(((64'sd5198775019 * QNum + QHalf) / QDen)),
    32'(-((64'sd19198292004 * QNum + QHalf) / QDen)),
    32'(((64'sd59054035642 * QNum + QHalf) / QDen)),
    32'(-((64'sd151968751364 * QNum + QHalf) / QDen)),
    32'(((64'sd319152932694 * QNum + QHalf) / QDen)),
    32'(-((64'sd531923007300 * QNum + QHalf) / QDen)),
    32'(((64'sd797884560593 * QNum + QHalf) / QDen))
  };

  typedef struct packed {
    logic neg;
    logic zero;
    logic sat_one;
    logic is_small;
    logic [29:0] y;
    logic signed [31:0] v;
    logic signed [31:0] acc;
  } pipe_t;

  function automatic logic signed [31:0] sat_q30(input logic signed [39:0] val);
    logic signed [31:0] res;
    if (val > 40'sh00_7fff_ffff) begin
      res = 32'sh7fff_ffff;
    end else if (val < -40'sh00_8000_0000) begin
      res = -32'sh8000_0000;
    end else begin
      res = val[31:0];
    end
    return res;
  endfunction

endpackage

### src/ncdf_channels.sv
// ncdf channel interfaces: valid/ready streams for z input, probability output
// and limit register writes; uses no package
`timescale 1ns / 1ps

interface ncdf_z_if;
  logic valid;
  logic ready;
  logic signed [31:0] z_value;
  modport source (output valid, output z_value, input ready);
  modport sink (input valid, input z_value, output ready);
endinterface

interface ncdf_prob_if;
  logic valid;
  logic ready;
  logic [31:0] probability;
  modport source (output valid, output probability, input ready);
  modport sink (input valid, input probability, output ready);
endinterface

interface ncdf_limit_if;
  logic valid;
  logic ready;
  logic [30:0] z_limit;
  modport source (output valid, output z_limit, input ready);
  modport sink (input valid, input z_limit, output ready);
endinterface

### src/ncdf_horner_stage.sv
// ncdf_horner_stage: one registered horner step, acc = sat(round(acc * v) + coef)
// depends on ncdf_pkg
`timescale 1ns / 1ps

module ncdf_horner_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  logic                 in_valid,
  input  ncdf_pkg::pipe_t      in_word,
  input  logic signed [31:0]   coef,
  output logic                 out_valid,
  output ncdf_pkg::pipe_t      out_word
);

  logic signed [63:0] prod;
  logic signed [63:0] prod_rnd;
  logic signed [33:0] prod_q30;
  logic signed [39:0] sum;
  ncdf_pkg::pipe_t word_next;

  always_comb begin
    prod = 64'(in_word.acc) * 64'(in_word.v);
    // round to nearest, ties toward plus infinity
    prod_rnd = prod + 64'sd536870912;
    prod_q30 = prod_rnd[63:30];
    sum = 40'(prod_q30) + 40'(coef);
    word_next = in_word;
    word_next.acc = ncdf_pkg::sat_q30(sum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word <= word_next;
    end
  end

endmodule

### src/normal_cdf_polynomial_unit.sv
// normal_cdf_polynomial_unit: pipelined lower-tail normal probability
// depends on ncdf_pkg, ncdf_channels and ncdf_horner_stage
`timescale 1ns / 1ps

// Takes one Q8.24 z word per cycle unless stalled and returns P(Z <= z) as
// unsigned Q1.31 (2^31 = 1.0). The datapath is an 18-register pipeline:
// magnitude, region, limit check and y-2 offset; the y*y product and horner
// start value; fourteen horner steps, each one 32x32 multiply with round,
// add and saturate; the final 2y product; and the output register. Each
// stage holds its word while the stage after it is full and stalled, so
// empty stages keep filling even when the output is not taken.
// The z_limit register may be written whenever the limit channel is valid;
// it is sampled as a word enters.
module normal_cdf_polynomial_unit (
  input  logic                 clk,
  input  logic                 rst,
  ncdf_z_if.sink               z_in,
  ncdf_prob_if.source          prob_out,
  ncdf_limit_if.sink           cfg
);

  localparam int STEPS = ncdf_pkg::HORNER_STEPS;

  logic [30:0] z_limit;

  // entry stage
  logic s0_valid;
  ncdf_pkg::pipe_t s0_word;
  ncdf_pkg::pipe_t s0_next;
  logic en_s0;

  // horner chain, index 0 is the stage that sets up v and acc
  logic h_valid [STEPS + 1];
  ncdf_pkg::pipe_t h_word [STEPS + 1];
  logic h_en [STEPS + 1];
  ncdf_pkg::pipe_t h0_next;
  logic h0_valid;
  ncdf_pkg::pipe_t h0_word;

  // final product and output stages
  logic f_valid;
  logic f_neg;
  logic f_zero;
  logic signed [31:0] f_x;
  logic signed [31:0] f_x_next;
  logic en_f;
  logic en_o;
  logic o_valid;
  logic [31:0] o_prob;
  logic [31:0] o_prob_next;

  // limit register
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      z_limit <= ncdf_pkg::Z_LIMIT_RESET;
    end else if (cfg.valid) begin
      z_limit <= cfg.z_limit;
    end
  end

  // stall chain: a stage moves when it is empty or the next one moves
  assign en_o = !o_valid || prob_out.ready;
  assign en_f = !f_valid || en_o;
  assign h_en[STEPS] = !h_valid[STEPS] || en_f;
  genvar gi;
  generate
    for (gi = 0; gi < STEPS; gi++) begin : g_en
      assign h_en[gi] = !h_valid[gi] || h_en[gi + 1];
    end
  endgenerate
  assign en_s0 = !s0_valid || h_en[0];
  assign z_in.ready = en_s0;

  // entry: magnitude, region, limit and y - 2
  logic [31:0] mag;
  logic signed [38:0] t_wide;

  always_comb begin
    mag = z_in.z_value[31] ? 32'(-z_in.z_value) : 32'(z_in.z_value);
    t_wide = 39'({mag, 5'b0}) - 39'sd2147483648;
    s0_next.neg = z_in.z_value[31];
    s0_next.zero = (z_in.z_value == 32'sd0);
    s0_next.sat_one = (mag >= 32'(z_limit));
    s0_next.is_small = (mag < ncdf_pkg::TWO_Q824);
    s0_next.y = {mag[24:0], 5'b0};
    s0_next.v = ncdf_pkg::sat_q30(40'(t_wide));
    s0_next.acc = 32'sd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en_s0) begin
      s0_valid <= z_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_s0) begin
      s0_word <= s0_next;
    end
  end

  // setup: w = y*y for the small region, horner start value
  logic [63:0] yy;
  logic [63:0] yy_rnd;

  always_comb begin
    yy = 64'(s0_word.y) * 64'(s0_word.y);
    yy_rnd = yy + 64'd536870912;
    h0_next = s0_word;
    if (s0_word.is_small) begin
      h0_next.v = yy_rnd[61:30];
      h0_next.acc = ncdf_pkg::SMALL_COEF[0];
    end else begin
      h0_next.acc = ncdf_pkg::LARGE_COEF[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      h0_valid <= 1'b0;
    end else if (h_en[0]) begin
      h0_valid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (h_en[0]) begin
      h0_word <= h0_next;
    end
  end

  assign h_valid[0] = h0_valid;
  assign h_word[0] = h0_word;

  generate
    for (gi = 1; gi <= STEPS; gi++) begin : g_step
      logic signed [31:0] step_coef;
      assign step_coef = h_word[gi - 1].is_small ? ncdf_pkg::SMALL_COEF[gi]
                                                 : ncdf_pkg::LARGE_COEF[gi];
      ncdf_horner_stage u_step (
        .clk       (clk),
        .rst       (rst),
        .advance   (h_en[gi]),
        .in_valid  (h_valid[gi - 1]),
        .in_word   (h_word[gi - 1]),
        .coef      (step_coef),
        .out_valid (h_valid[gi]),
        .out_word  (h_word[gi])
      );
    end
  endgenerate

  // final: small region multiplies by 2y, special cases override
  logic signed [63:0] fy;
  logic signed [63:0] fy_rnd;
  logic signed [34:0] fy_q;

  always_comb begin
    fy = 64'(h_word[STEPS].acc) * 64'(signed'({2'b00, h_word[STEPS].y}));
    fy_rnd = fy + 64'sd268435456;
    fy_q = fy_rnd[63:29];
    if (h_word[STEPS].zero) begin
      f_x_next = 32'sd0;
    end else if (h_word[STEPS].sat_one) begin
      f_x_next = ncdf_pkg::Q30_ONE;
    end else if (h_word[STEPS].is_small) begin
      f_x_next = ncdf_pkg::sat_q30(40'(fy_q));
    end else begin
      f_x_next = h_word[STEPS].acc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (en_f) begin
      f_valid <= h_valid[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en_f) begin
      f_x <= f_x_next;
      f_neg <= h_word[STEPS].neg;
      f_zero <= h_word[STEPS].zero;
    end
  end

  // output: (1 +- x) / 2 in Q1.31, clamped to 0 .. 1
  logic signed [33:0] p_wide;

  always_comb begin
    if (!f_neg && !f_zero) begin
      p_wide = 34'(ncdf_pkg::Q30_ONE) + 34'(f_x);
    end else begin
      p_wide = 34'(ncdf_pkg::Q30_ONE) - 34'(f_x);
    end
    if (p_wide < 34'sd0) begin
      o_prob_next = 32'd0;
    end else if (p_wide > 34'sh0_8000_0000) begin
      o_prob_next = 32'h8000_0000;
    end else begin
      o_prob_next = p_wide[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (en_o) begin
      o_valid <= f_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_o) begin
      o_prob <= o_prob_next;
    end
  end

  assign prob_out.valid = o_valid;
  assign prob_out.probability = o_prob;

`ifndef SYNTH
  a_prob_range: assert property (@(posedge clk) disable iff (rst)
    prob_out.valid |-> prob_out.probability <= 32'h8000_0000)
    else $error("probability above one");

  a_entry_fills: assert property (@(posedge clk) disable iff (rst)
    z_in.valid && z_in.ready |=> s0_valid)
    else $error("accepted word not captured at entry");

  a_final_holds: assert property (@(posedge clk) disable iff (rst)
    f_valid && !en_f |=> f_valid && $stable(f_x))
    else $error("stalled final stage lost its word");

  a_zero_half: assert property (@(posedge clk) disable iff (rst)
    h_valid[STEPS] && h_word[STEPS].zero && en_f |=> f_x == 32'sd0)
    else $error("zero score not forced to one half");
`endif

endmodule

### tb/tb_top.sv
// tb_top: self-checking bench for normal_cdf_polynomial_unit, a streaming
// lower-tail normal probability pipeline with a writable z limit register
// depends on ncdf_channels (rtl interfaces) and the unit itself
`timescale 1ns / 1ps

module tb_top;

  localparam longint Q230_ONE = 64'sd1073741824;
  localparam longint TWO_Q824 = 64'sd33554432;
  localparam logic [30:0] LIMIT_AT_RESET = 31'd100663296;
  localparam logic [30:0] LIMIT_MAX = 31'h7fff_ffff;
  localparam logic [30:0] LIMIT_TWO = 31'h0200_0000;

  typedef struct {
    logic [31:0] z;
    logic [31:0] prob;
  } pending_prob_t;

  logic clk;
  logic rst;

  ncdf_z_if z_bus ();
  ncdf_prob_if prob_bus ();
  ncdf_limit_if limit_bus ();

  normal_cdf_polynomial_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .z_in     (z_bus.sink),
    .prob_out (prob_bus.source),
    .cfg      (limit_bus.sink)
  );

  // coefficients in units of 1e-12, highest power first
  longint small_dec [9] = '{
    64'sd124818987, -64'sd1075204047, 64'sd5198775019, -64'sd19198292004,
    64'sd59054035642, -64'sd151968751364, 64'sd319152932694,
    -64'sd531923007300, 64'sd797884560593
  };
  longint large_dec [15] = '{
    -64'sd45255659, 64'sd152529290, -64'sd19538132, -64'sd676904986,
    64'sd1390604284, -64'sd794620820, -64'sd2034254874, 64'sd6549791214,
    -64'sd10557625006, 64'sd11630447319, -64'sd9279453341, 64'sd5353579108,
    -64'sd2141268741, 64'sd535310849, 64'sd999936657524
  };

  pending_prob_t pending_probs [$];
  logic [30:0] model_limit = LIMIT_AT_RESET;
  bit gaps_on = 1'b1;
  bit stalls_on = 1'b1;
  int hold_left = 0;
  int score_count = 0;
  int checked_count = 0;
  int limit_writes = 0;
  int mismatch_count = 0;

  // ---------------- probability predictor ----------------

  // magnitude rounded to nearest, sign applied after (symmetric)
  function automatic longint dec_to_q230(input longint d);
    longint m;
    m = (d < 0) ? -d : d;
    m = (m * 64'sd262144 + 64'sd122070312) / 64'sd244140625;
    return (d < 0) ? -m : m;
  endfunction

  // round to nearest, ties toward plus infinity
  function automatic longint round_shift_q(input longint p, input int n);
    return (p + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic longint clamp_q230(input longint v);
    longint r;
    r = v;
    if (v > 64'sd2147483647) r = 64'sd2147483647;
    if (v < -64'sd2147483648) r = -64'sd2147483648;
    return r;
  endfunction

  function automatic longint eval_horner(input bit use_small, input longint v);
    longint acc;
    longint c;
    int count;
    int i;
    count = use_small ? 9 : 15;
    acc = dec_to_q230(use_small ? small_dec[0] : large_dec[0]);
    for (i = 1; i < count; i++) begin
      c = dec_to_q230(use_small ? small_dec[i] : large_dec[i]);
      acc = clamp_q230(round_shift_q(acc * v, 30) + c);
    end
    return acc;
  endfunction

  function automatic logic [31:0] predict_probability(input logic [31:0] raw,
                                                      input logic [30:0] limit);
    bit neg;
    longint mag;
    longint x;
    longint y;
    longint w;
    longint p;
    neg = raw[31];
    mag = {32'd0, (neg ? (32'd0 - raw) : raw)};
    if (raw == 32'd0) begin
      x = 0;
    end else if (mag >= longint'({33'd0, limit})) begin
      x = Q230_ONE;
    end else if (mag < TWO_Q824) begin
      y = mag <<< 5;
      w = round_shift_q(y * y, 30);
      x = clamp_q230(round_shift_q(eval_horner(1'b1, w) * y, 29));
    end else begin
      x = eval_horner(1'b0, clamp_q230((mag <<< 5) - 2 * Q230_ONE));
    end
    p = (!neg && raw != 32'd0) ? Q230_ONE + x : Q230_ONE - x;
    if (p < 0) p = 0;
    if (p > 2 * Q230_ONE) p = 2 * Q230_ONE;
    return p[31:0];
  endfunction

  // ---------------- shared tasks ----------------

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  // offers one z word and waits for it to be taken
  task automatic send_z(input logic [31:0] raw);
    pending_prob_t entry;
    if (gaps_on && $urandom_range(99) < 10) begin
      z_bus.valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    z_bus.valid <= 1'b1;
    z_bus.z_value <= raw;
    do @(posedge clk); while (!z_bus.ready);
    entry.z = raw;
    entry.prob = predict_probability(raw, model_limit);
    pending_probs.push_back(entry);
    score_count++;
  endtask

  task automatic drain_results();
    z_bus.valid <= 1'b0;
    while (pending_probs.size() != 0) @(posedge clk);
  endtask

  task automatic write_limit(input logic [30:0] value);
    drain_results();
    limit_bus.valid <= 1'b1;
    limit_bus.z_limit <= value;
    do @(posedge clk); while (!limit_bus.ready);
    limit_bus.valid <= 1'b0;
    model_limit = value;
    limit_writes++;
  endtask

  // mix of small region, mid range, boundaries and raw 32-bit words
  function automatic logic [31:0] pick_score(input logic [30:0] limit);
    int sel;
    logic [31:0] m;
    sel = $urandom_range(99);
    if (sel < 20) begin
      m = $urandom_range(32'h01ff_ffff, 0);
    end else if (sel < 62) begin
      m = $urandom_range(32'h0800_0000, 0);
    end else if (sel < 77) begin
      m = {1'b0, limit} + $urandom_range(8) - 32'd4;
    end else if (sel < 83) begin
      m = 32'h0200_0000 + $urandom_range(8) - 32'd4;
    end else begin
      return $urandom();
    end
    return $urandom_range(1) ? (32'd0 - m) : m;
  endfunction

  task automatic send_random_scores(input int count);
    repeat (count) send_z(pick_score(model_limit));
  endtask

  // ---------------- tests ----------------

  // reset limit of 6.0 still in force
  task automatic test_directed_scores();
    logic [31:0] scores [15] = '{
      32'h0000_0000, 32'h0000_0001, 32'hffff_ffff, 32'h0080_0000, 32'hff80_0000,
      32'h0100_0000, 32'h01ff_ffff, 32'h0200_0000, 32'hfdff_ffff, 32'h0400_0000,
      32'h05ff_ffff, 32'h0600_0000, 32'hfa00_0000, 32'h7fff_ffff, 32'h8000_0000
    };
    foreach (scores[i]) send_z(scores[i]);
  endtask

  task automatic test_limit_extremes();
    // zero limit: every nonzero score saturates
    write_limit(31'd0);
    send_z(32'h0000_0000);
    send_z(32'h0000_0001);
    send_z(32'h8000_0000);
    // full limit: y-2 saturates before the horner chain
    write_limit(LIMIT_MAX);
    send_z(32'h0800_0000);
    send_z(32'hf800_0000);
    send_z(32'h7fff_fffe);
    send_z(32'h7fff_ffff);
    send_z(32'h8000_0000);
    // limit on the region boundary
    write_limit(LIMIT_TWO);
    send_z(32'h01ff_ffff);
    send_z(32'hfe00_0000);
    write_limit(LIMIT_AT_RESET);
  endtask

  // receiver holds off long enough for the pipeline to back up to the input
  task automatic test_output_backpressure();
    drain_results();
    gaps_on = 1'b0;
    hold_left = 200;
    send_random_scores(60);
    drain_results();
    gaps_on = 1'b1;
  endtask

  task automatic test_random_scores();
    send_random_scores(400);
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    send_random_scores(200);
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    write_limit(31'($urandom_range(32'h2000_0000, 32'h0200_0000)));
    send_random_scores(300);
    write_limit(LIMIT_MAX);
    send_random_scores(300);
    write_limit(31'd0);
    send_random_scores(100);
    write_limit(31'($urandom_range(32'h0200_0000, 0)));
    send_random_scores(150);
    write_limit(LIMIT_AT_RESET);
  endtask

  // ---------------- processes ----------------

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d probabilities outstanding", pending_probs.size());
    $display("== FAIL ==");
    $finish;
  end

  // output ready: random stalls, plus an occasional long hold-off
  initial begin
    prob_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        prob_bus.ready <= 1'b0;
        hold_left--;
      end else if (stalls_on) begin
        prob_bus.ready <= ($urandom_range(99) >= 10);
      end else begin
        prob_bus.ready <= 1'b1;
      end
    end
  end

  initial begin
    pending_prob_t head;
    forever begin
      @(posedge clk);
      if (!rst && prob_bus.valid && prob_bus.ready) begin
        if (pending_probs.size() == 0) begin
          report_mismatch($sformatf("unexpected probability word %h", prob_bus.probability));
        end else begin
          head = pending_probs.pop_front();
          checked_count++;
          if (prob_bus.probability !== head.prob) begin
            report_mismatch($sformatf("z %h: probability %h, predicted %h",
                                      head.z, prob_bus.probability, head.prob));
          end
        end
      end
    end
  end

  initial begin
    rst <= 1'b1;
    z_bus.valid <= 1'b0;
    z_bus.z_value <= 32'd0;
    limit_bus.valid <= 1'b0;
    limit_bus.z_limit <= 31'd0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_directed_scores();
    test_limit_extremes();
    test_output_backpressure();
    test_random_scores();

    drain_results();
    // room for any stray word to arrive
    repeat (40) @(posedge clk);
    if (pending_probs.size() != 0) begin
      report_mismatch($sformatf("%0d probabilities never arrived", pending_probs.size()));
    end

    $display("ran %0d z words through %0d limit settings, %0d probabilities checked",
             score_count, limit_writes + 1, checked_count);
    $display("covered both regions, zero, saturation, extreme words and output hold-off");
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
